>>> rtl/assert_macros.svh
// Assertion macros for the RTL modules of the scheduler.
// Each macro expects clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pts_pkg.sv
// Package for the priority task scheduler: operation codes, task run states
// and sequencer states. No dependencies.
package pts_pkg;

  // Operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_DELAY    = 3'd1,
    OP_SUSPEND  = 3'd2,
    OP_ACTIVATE = 3'd3,
    OP_TICK     = 3'd4
  } op_t;

  // Run state of one task entry
  typedef enum logic [1:0] {
    RS_READY     = 2'd0,
    RS_RUNNING   = 2'd1,
    RS_WAITING   = 2'd2,
    RS_SUSPENDED = 2'd3
  } run_st_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_PICK,
    S_DONE
  } state_t;

endpackage

>>> rtl/pts_in_if.sv
// Input channel of the priority task scheduler: valid/ready plus one
// operation item. Depends on nothing.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  task_index;
  logic [7:0]  task_priority;
  logic [31:0] delay_ticks;
  logic        auto_start;

  modport source (output valid, op, task_index, task_priority, delay_ticks, auto_start,
                  input ready);
  modport sink   (input valid, op, task_index, task_priority, delay_ticks, auto_start,
                  output ready);
endinterface

>>> rtl/pts_out_if.sv
// Result channel of the priority task scheduler: valid/ready plus one
// result item. Depends on nothing.
interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  running_task;
  logic        switched;
  logic [2:0]  new_handle;
  logic        create_failed;
  logic [31:0] tick_count;
  logic [3:0]  tasks_in_use;

  modport source (output valid, running_task, switched, new_handle, create_failed,
                  tick_count, tasks_in_use, input ready);
  modport sink   (input valid, running_task, switched, new_handle, create_failed,
                  tick_count, tasks_in_use, output ready);
endinterface

>>> rtl/priority_task_scheduler_unit.sv
// Priority task scheduler: a table of up to MAX_TASKS tasks with one shared
// scan unit that applies tick countdowns and picks the task to run. Create and
// an unused op code go from apply straight to done. Delay, suspend, activate
// and tick also scan the table and pick a task: the scan unit visits one table
// entry per cycle through a single read port per table, scores the last entry
// in the cycle after its read and then sees the scan run dry.
// A finished result waits in an output register, so the next item is taken
// while the result is still unclaimed. Depends on pts_pkg, pts_in_if,
// pts_out_if and assert_macros.svh.
`include "assert_macros.svh"

module priority_task_scheduler_unit import pts_pkg::*; #(
  parameter int MAX_TASKS  = 8,
  parameter int TICK_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  pts_in_if.sink    in_ch,
  pts_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // Sequencer and architectural state
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        total_r, total_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [TICK_WIDTH-1:0]   gticks_r, gticks_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic                    ev_vld_r, ev_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Captured item fields
  logic [2:0]              op_r, op_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic [7:0]              prio_r, prio_nxt;
  logic [TICK_WIDTH-1:0]   dly_r, dly_nxt;
  logic                    auto_r, auto_nxt;

  // Scan and dispatch working registers
  logic [IDX_W-1:0]        ev_idx_r, ev_idx_nxt;
  logic [7:0]              top_r, top_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic                    sw_r, sw_nxt;
  logic [IDX_W-1:0]        handle_r, handle_nxt;
  logic                    failed_r, failed_nxt;

  // Result register
  logic [2:0]              o_run_r, o_run_nxt;
  logic                    o_sw_r, o_sw_nxt;
  logic [2:0]              o_handle_r, o_handle_nxt;
  logic                    o_failed_r, o_failed_nxt;
  logic [31:0]             o_ticks_r, o_ticks_nxt;
  logic [3:0]              o_total_r, o_total_nxt;

  // Task table memories
  logic [7:0]              prio_mem [MAX_TASKS];
  run_st_t                 st_mem   [MAX_TASKS];
  logic [TICK_WIDTH-1:0]   wt_mem   [MAX_TASKS];
  logic [7:0]              pr_q_r;
  run_st_t                 st_q_r;
  logic [TICK_WIDTH-1:0]   wt_q_r;

  logic [IDX_W-1:0]        rd_addr;
  logic                    pr_we;
  logic                    st_we;
  logic [IDX_W-1:0]        st_waddr;
  run_st_t                 st_wdata;
  logic                    wt_we;
  logic [IDX_W-1:0]        wt_waddr;
  logic [TICK_WIDTH-1:0]   wt_wdata;

  // Shared scan unit signals
  logic                    issue;
  run_st_t                 ev_st;
  logic [TICK_WIDTH-1:0]   wt_dec;

  // Width adapters between item fields and internal widths
  logic [63:0]             dly_ext;
  logic [63:0]             idx_ext;
  logic [63:0]             total_ext;
  logic [63:0]             cur_ext;
  logic [63:0]             gticks_ext;
  logic [63:0]             handle_ext;

  assign dly_ext    = 64'(in_ch.delay_ticks);
  assign idx_ext    = 64'(idx_r);
  assign total_ext  = 64'(total_r);
  assign cur_ext    = 64'(cur_r);
  assign gticks_ext = 64'(gticks_r);
  assign handle_ext = 64'(handle_r);

  assign rd_addr = scan_r[IDX_W-1:0];
  assign wt_dec  = wt_q_r - TICK_WIDTH'(1);

  // Handshake ports
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.running_task  = o_run_r;
  assign out_ch.switched      = o_sw_r;
  assign out_ch.new_handle    = o_handle_r;
  assign out_ch.create_failed = o_failed_r;
  assign out_ch.tick_count    = o_ticks_r;
  assign out_ch.tasks_in_use  = o_total_r;

  // Next state, table writes and scan unit
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    gticks_nxt    = gticks_r;
    scan_nxt      = scan_r;
    ev_vld_nxt    = ev_vld_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    prio_nxt      = prio_r;
    dly_nxt       = dly_r;
    auto_nxt      = auto_r;
    ev_idx_nxt    = ev_idx_r;
    top_nxt       = top_r;
    best_nxt      = best_r;
    sw_nxt        = sw_r;
    handle_nxt    = handle_r;
    failed_nxt    = failed_r;
    o_run_nxt     = o_run_r;
    o_sw_nxt      = o_sw_r;
    o_handle_nxt  = o_handle_r;
    o_failed_nxt  = o_failed_r;
    o_ticks_nxt   = o_ticks_r;
    o_total_nxt   = o_total_r;
    pr_we         = 1'b0;
    st_we         = 1'b0;
    st_waddr      = cur_r;
    st_wdata      = RS_READY;
    wt_we         = 1'b0;
    wt_waddr      = cur_r;
    wt_wdata      = dly_r;
    issue         = 1'b0;
    ev_st         = st_q_r;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          idx_nxt   = in_ch.task_index;
          prio_nxt  = in_ch.task_priority;
          dly_nxt   = dly_ext[TICK_WIDTH-1:0];
          auto_nxt  = in_ch.auto_start;
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        sw_nxt     = 1'b0;
        handle_nxt = '0;
        failed_nxt = 1'b0;
        scan_nxt   = '0;
        ev_vld_nxt = 1'b0;
        top_nxt    = '0;
        best_nxt   = '0;
        state_nxt  = S_SCAN;
        unique case (op_r)
          OP_CREATE: begin
            state_nxt = S_DONE;
            if (total_r >= CNT_W'(MAX_TASKS)) begin
              failed_nxt = 1'b1;
            end else begin
              handle_nxt = total_r[IDX_W-1:0];
              pr_we      = 1'b1;
              st_we      = 1'b1;
              st_waddr   = total_r[IDX_W-1:0];
              st_wdata   = auto_r ? RS_READY : RS_SUSPENDED;
              wt_we      = 1'b1;
              wt_waddr   = total_r[IDX_W-1:0];
              wt_wdata   = '0;
              total_nxt  = total_r + CNT_W'(1);
            end
          end
          OP_DELAY: begin
            st_we    = 1'b1;
            st_wdata = RS_WAITING;
            wt_we    = 1'b1;
          end
          OP_SUSPEND: begin
            st_we    = 1'b1;
            st_wdata = RS_SUSPENDED;
          end
          OP_ACTIVATE: begin
            if (idx_ext < total_ext) begin
              st_we    = 1'b1;
              st_waddr = idx_ext[IDX_W-1:0];
              st_wdata = RS_READY;
            end
          end
          OP_TICK: begin
            gticks_nxt = gticks_r + TICK_WIDTH'(1);
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCAN: begin
        // Issue one read per cycle, evaluate the entry read last cycle
        issue      = (scan_r < total_r);
        ev_vld_nxt = issue;
        ev_idx_nxt = rd_addr;
        if (issue) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        if (ev_vld_r) begin
          if (op_r == OP_TICK && st_q_r == RS_WAITING) begin
            wt_we    = 1'b1;
            wt_waddr = ev_idx_r;
            wt_wdata = wt_dec;
            if (wt_dec == '0) begin
              ev_st    = RS_RUNNING;
              st_we    = 1'b1;
              st_waddr = ev_idx_r;
              st_wdata = RS_RUNNING;
            end
          end
          // Ties go to the higher index
          if ((ev_st == RS_READY || ev_st == RS_RUNNING) && pr_q_r >= top_r) begin
            top_nxt  = pr_q_r;
            best_nxt = ev_idx_r;
          end
        end
        if (!issue && !ev_vld_r) begin
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        if (best_r != cur_r) begin
          cur_nxt  = best_r;
          sw_nxt   = 1'b1;
          st_we    = 1'b1;
          st_waddr = best_r;
          st_wdata = RS_RUNNING;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          o_run_nxt     = cur_ext[2:0];
          o_sw_nxt      = sw_r;
          o_handle_nxt  = handle_ext[2:0];
          o_failed_nxt  = failed_r;
          o_ticks_nxt   = gticks_ext[31:0];
          o_total_nxt   = total_ext[3:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      cur_r       <= '0;
      gticks_r    <= '0;
      scan_r      <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cur_r       <= cur_nxt;
      gticks_r    <= gticks_nxt;
      scan_r      <= scan_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    prio_r     <= prio_nxt;
    dly_r      <= dly_nxt;
    auto_r     <= auto_nxt;
    ev_idx_r   <= ev_idx_nxt;
    top_r      <= top_nxt;
    best_r     <= best_nxt;
    sw_r       <= sw_nxt;
    handle_r   <= handle_nxt;
    failed_r   <= failed_nxt;
    o_run_r    <= o_run_nxt;
    o_sw_r     <= o_sw_nxt;
    o_handle_r <= o_handle_nxt;
    o_failed_r <= o_failed_nxt;
    o_ticks_r  <= o_ticks_nxt;
    o_total_r  <= o_total_nxt;
  end

  // Task table: one write and one registered read per memory
  always_ff @(posedge clk) begin
    if (pr_we) begin
      prio_mem[total_r[IDX_W-1:0]] <= prio_r;
    end
    pr_q_r <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_q_r <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_q_r <= wt_mem[rd_addr];
  end

  // Assertions
  `ASSERT_ALWAYS(a_total_bound, total_r <= CNT_W'(MAX_TASKS), "task count above table size")
  `ASSERT_IMPLY(a_cur_in_use, cur_r != '0, cur_ext < total_ext, "current task not in use")
  `ASSERT_IMPLY(a_scan_bound, state_r == S_SCAN, scan_r <= total_r, "scan beyond task count")
  `ASSERT_NEXT(a_accept_apply, in_ch.valid && in_ch.ready, state_r == S_APPLY, "item not applied")
  `ASSERT_NEXT(a_total_hold, state_r == S_APPLY && op_r != OP_CREATE,
               total_r == $past(total_r), "task count changed without create")

endmodule
